// ----- hdl/bse_pkg.sv -----
// Shared types and constants for the Base64 stream encoder.
// Holds the queue entry type and the sextet-to-character lookup.
// No dependencies.
package bse_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CHARS_PER_ENTRY = 4;

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam logic [6:0] PLUS_CHAR = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;
    localparam logic [6:0] UPPER_A = 7'h41;
    localparam logic [6:0] LOWER_A = 7'h61;
    localparam logic [6:0] DIGIT_0 = 7'h30;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE = 2'd1;
    localparam logic [1:0] PHASE_TWO = 2'd2;

    typedef logic [1:0] phase_t;

    typedef struct packed {
        logic [CHARS_PER_ENTRY-1:0][6:0] chars;
        logic [1:0]                      last_idx;
        logic                            final_flag;
    } entry_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] vv;
        logic [6:0] ch;
        vv = {1'b0, v};
        if (v < 6'd26)
        begin
            ch = UPPER_A + vv;
        end
        else if (v < 6'd52)
        begin
            ch = LOWER_A + vv - 7'd26;
        end
        else if (v < 6'd62)
        begin
            ch = DIGIT_0 + vv - 7'd52;
        end
        else if (v == 6'd62)
        begin
            ch = PLUS_CHAR;
        end
        else
        begin
            ch = SLASH_CHAR;
        end
        return ch;
    endfunction

endpackage

// ----- hdl/bse_front.sv -----
// Front end: takes one byte per transfer and builds a queue entry of characters.
// Keeps leftover bits and group phase. Depends on bse_pkg.
module bse_front
    import bse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       queue_full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       push,
    output entry_t     push_entry
);

    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     np;
    logic [3:0] nl;
    entry_t     e;

    assign push = byte_valid && !queue_full;

    always_comb
    begin
        e = '0;
        nl = 4'd0;
        np = PHASE_START;
        unique case (phase_reg)
            PHASE_ONE:
            begin
                e.chars[0] = sextet_char({leftover_reg[1:0], data_byte[7:4]});
                e.last_idx = 2'd0;
                nl = data_byte[3:0];
                np = PHASE_TWO;
            end
            PHASE_TWO:
            begin
                e.chars[0] = sextet_char({leftover_reg, data_byte[7:6]});
                e.chars[1] = sextet_char(data_byte[5:0]);
                e.last_idx = 2'd1;
                nl = 4'd0;
                np = PHASE_START;
            end
            default:
            begin
                e.chars[0] = sextet_char(data_byte[7:2]);
                e.last_idx = 2'd0;
                nl = {2'b00, data_byte[1:0]};
                np = PHASE_ONE;
            end
        endcase

        leftover_next = nl;
        phase_next = np;
        if (final_byte)
        begin
            e.final_flag = 1'b1;
            if (np == PHASE_ONE)
            begin
                e.chars[1] = sextet_char({nl[1:0], 4'b0000});
                e.chars[2] = PAD_CHAR;
                e.chars[3] = PAD_CHAR;
                e.last_idx = 2'd3;
            end
            else if (np == PHASE_TWO)
            begin
                e.chars[1] = sextet_char({nl, 2'b00});
                e.chars[2] = PAD_CHAR;
                e.last_idx = 2'd2;
            end
            leftover_next = 4'd0;
            phase_next = PHASE_START;
        end
    end

    assign push_entry = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_reg <= 4'd0;
            phase_reg <= PHASE_START;
        end
        else if (push)
        begin
            leftover_reg <= leftover_next;
            phase_reg <= phase_next;
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase left its range");

endmodule

// ----- hdl/bse_queue.sv -----
// Two-entry queue between front and back ends.
// Holds encoded character groups in flip-flops. Depends on bse_pkg.
module bse_queue
    import bse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ----- hdl/bse_back.sv -----
// Back end: walks each queue entry one character per transfer.
// Drives the registered output channel. Depends on bse_pkg.
module bse_back
    import bse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    input  logic       char_stall,
    output logic       char_valid,
    output logic [6:0] code_char,
    output logic       final_char
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [6:0] char_reg;
    logic       final_reg;
    logic       load;
    logic       last;

    assign load = !valid_reg || !char_stall;
    assign last = (idx_reg == head_entry.last_idx);
    assign pop = load && head_valid && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            char_reg <= head_entry.chars[idx_reg];
            final_reg <= head_entry.final_flag && last;
        end
    end

    assign char_valid = valid_reg;
    assign code_char = char_reg;
    assign final_char = final_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg <= head_entry.last_idx)
        else $error("character index past end of entry");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 2'd0)
        else $error("character index not rewound while queue empty");

endmodule

// ----- hdl/base64_stream_encoder_top.sv -----
// Base64 stream encoder: one byte per input transfer, one character per output transfer.
// The first character of a byte passes the queue write, then the output register.
// Throughput: one character per cycle while char_stall is low, set by the output register;
// a byte yields one or two characters, a final byte two to four. A two-entry queue lets
// bytes enter while characters drain.
// Reset (rst_n low, asynchronous) clears phase, leftover bits, queue and output valid.
module base64_stream_encoder_top
    import bse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] code_char,
    output logic       final_char
);

    logic   push;
    logic   pop;
    logic   full;
    logic   head_valid;
    entry_t push_entry;
    entry_t head_entry;

    assign byte_stall = full;

    bse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .queue_full (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    bse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    bse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .char_stall (char_stall),
        .char_valid (char_valid),
        .code_char  (code_char),
        .final_char (final_char)
    );

endmodule

// ----- sim/base64_stream_encoder_top_tb.sv -----
// Self-checking testbench for base64_stream_encoder_top: drives byte messages, predicts
// the Base64 characters with a scoreboard class and checks every character transfer.
// Depends on bse_pkg and the encoder RTL.
module base64_stream_encoder_top_tb
    import bse_pkg::*;
;

    typedef struct {
        bit [6:0] code;
        bit       last;
    } b64_char_t;

    class b64_char_board;
        b64_char_t pending[$];
        bit [3:0]  leftover;
        bit [1:0]  phase;
        int        errors;
        string     alphabet;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            leftover = 4'd0;
            phase = PHASE_START;
            errors = 0;
        endfunction

        function void push_char(bit [6:0] c);
            b64_char_t ch;
            ch.code = c;
            ch.last = 1'b0;
            pending = {pending, ch};
        endfunction

        function void push_sextet(bit [5:0] v);
            byte ascii;
            ascii = alphabet[v];
            push_char(ascii[6:0]);
        endfunction

        function void note_byte(bit [7:0] b, bit fin);
            case (phase)
                PHASE_ONE:
                begin
                    push_sextet({leftover[1:0], b[7:4]});
                    leftover = b[3:0];
                    phase = PHASE_TWO;
                end
                PHASE_TWO:
                begin
                    push_sextet({leftover, b[7:6]});
                    push_sextet(b[5:0]);
                    leftover = 4'd0;
                    phase = PHASE_START;
                end
                default:
                begin
                    push_sextet(b[7:2]);
                    leftover = {2'b00, b[1:0]};
                    phase = PHASE_ONE;
                end
            endcase
            if (fin)
            begin
                if (phase == PHASE_ONE)
                begin
                    push_sextet({leftover[1:0], 4'd0});
                    push_char(PAD_CHAR);
                    push_char(PAD_CHAR);
                end
                else if (phase == PHASE_TWO)
                begin
                    push_sextet({leftover, 2'd0});
                    push_char(PAD_CHAR);
                end
                pending[pending.size() - 1].last = 1'b1;
                leftover = 4'd0;
                phase = PHASE_START;
            end
        endfunction

        function void check_char(bit [6:0] c, bit fin);
            b64_char_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, got %h final_char %b",
                         $time, c, fin);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.code != c)
            begin
                $display("%0t: code_char mismatch: expected %h, got %h", $time, want.code, c);
                errors++;
            end
            if (want.last != fin)
            begin
                $display("%0t: final_char mismatch: expected %b, got %b", $time, want.last, fin);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BYTES = 410;
    localparam int CALM_AFTER = 360;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte = 8'd0;
    logic       final_byte = 1'b0;
    logic       char_valid;
    logic       char_stall = 1'b0;
    logic [6:0] code_char;
    logic       final_char;

    b64_char_board encoder_board = new();
    logic [7:0]    message_bytes[$];
    bit            calm = 1'b0;
    int            bytes_sent = 0;
    int            idle_cycles = 0;

    base64_stream_encoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .code_char  (code_char),
        .final_char (final_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                encoder_board.note_byte(data_byte, final_byte);
            end
            if (char_valid && !char_stall)
            begin
                encoder_board.check_char(code_char, final_char);
            end
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("base64_stream_encoder_top test failed");
                $finish;
            end
        end
    end

    // Stall the character side in random bursts; hold it open once calm.
    initial
    begin
        forever
        begin
            if (!calm && rst_n && $urandom_range(0, 3) == 0)
            begin
                char_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                char_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        byte_valid <= 1'b1;
        data_byte <= b;
        final_byte <= fin;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < message_bytes.size(); i++)
        begin
            send_byte(message_bytes[i], i == message_bytes.size() - 1);
            maybe_gap();
        end
        message_bytes.delete();
    endtask

    task automatic drain_chars();
        byte_valid <= 1'b0;
        do @(posedge clk); while (encoder_board.pending.size() != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return 8'h00;
        end
        else if (sel == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
        begin
            return $urandom_range(1, 4);
        end
        else if (sel < 19)
        begin
            return $urandom_range(5, 16);
        end
        return $urandom_range(17, 40);
    endfunction

    initial
    begin
        int len;
        int k;
        bit pressed;
        pressed = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        message_bytes = '{8'h00};
        send_message();
        message_bytes = '{8'hFF};
        send_message();
        message_bytes = '{8'hFB, 8'hFF};
        send_message();
        message_bytes = '{8'h00, 8'h00, 8'h00};
        send_message();
        message_bytes = '{8'hFF, 8'hFF, 8'hFF};
        send_message();
        message_bytes = '{8'hFB, 8'hEF, 8'hBE};
        send_message();
        message_bytes = '{8'h4D, 8'h61, 8'h6E, 8'h00};
        send_message();
        message_bytes = '{8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
        send_message();

        drain_chars();

        k = 0;
        while (k < RANDOM_BYTES)
        begin
            len = pick_length();
            repeat (len) message_bytes = {message_bytes, pick_byte()};
            k += len;
            if (bytes_sent >= CALM_AFTER)
            begin
                calm = 1'b1;
            end
            send_message();
            if (!pressed && k >= RANDOM_BYTES / 2)
            begin
                pressed = 1'b1;
                drain_chars();
            end
        end

        byte_valid <= 1'b0;
        while (encoder_board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (encoder_board.errors == 0 && encoder_board.pending.size() == 0)
        begin
            $display("base64_stream_encoder_top test passed");
        end
        else
        begin
            $display("base64_stream_encoder_top test failed");
        end
        $finish;
    end
endmodule
